FILE: src/oaisr_pkg.sv
// Shared types and constants for the ordered array list block.
// No dependencies.
package oaisr_pkg;

  localparam int unsigned CountW = 6;
  localparam int unsigned PosW   = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned OpW    = 2;
  localparam int unsigned StatW  = 2;
  localparam logic [CountW-1:0] CapReset = 6'd32;

  typedef enum logic [OpW-1:0] {
    OP_SEARCH = 2'd0,
    OP_APPEND = 2'd1,
    OP_INSERT = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_APPEND,
    CMD_INSERT,
    CMD_REMOVE
  } cmd_kind_t;

  // broadcast from the control to every cell
  typedef struct packed {
    cmd_kind_t         kind;
    logic [PosW-1:0]   pos;
    logic [CountW-1:0] count;
  } cell_cmd_t;

endpackage

FILE: src/oaisr_ifs.sv
// Channel interfaces: request, response and capacity write.
// Depends on oaisr_pkg for widths.
interface oaisr_req_if;
  logic                             valid;
  logic                             ready;
  logic [oaisr_pkg::OpW-1:0]        op;
  logic [oaisr_pkg::PosW-1:0]       position;
  logic signed [oaisr_pkg::DataW-1:0] value;
  modport source (output valid, op, position, value, input ready);
  modport sink   (input valid, op, position, value, output ready);
endinterface

interface oaisr_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [oaisr_pkg::StatW-1:0]  status;
  logic [oaisr_pkg::PosW-1:0]   found_position;
  logic [oaisr_pkg::CountW-1:0] count_after;
  modport source (output valid, status, found_position, count_after, input ready);
  modport sink   (input valid, status, found_position, count_after, output ready);
endinterface

interface oaisr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [oaisr_pkg::CountW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: src/oaisr_cell.sv
// One storage cell of the list: holds a word, shifts with its neighbors,
// and compares against the search key. Depends on oaisr_pkg.
module oaisr_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                             clk,
  input  oaisr_pkg::cell_cmd_t             cmd,
  input  logic [oaisr_pkg::DataW-1:0]      value,
  input  logic [oaisr_pkg::DataW-1:0]      key,
  input  logic [oaisr_pkg::DataW-1:0]      left_data,
  input  logic [oaisr_pkg::DataW-1:0]      right_data,
  output logic [oaisr_pkg::DataW-1:0]      data,
  output logic                             match
);

  always_ff @(posedge clk) begin
    unique case (cmd.kind)
      oaisr_pkg::CMD_APPEND: begin
        if (IDX == int'(cmd.count)) data <= value;
      end
      oaisr_pkg::CMD_INSERT: begin
        if (IDX > int'(cmd.pos)) data <= left_data;
        else if (IDX == int'(cmd.pos)) data <= value;
      end
      oaisr_pkg::CMD_REMOVE: begin
        if (IDX >= int'(cmd.pos)) data <= right_data;
      end
      default: begin
      end
    endcase
  end

  assign match = (data == key) && (IDX < int'(cmd.count));

endmodule

FILE: src/ordered_array_insert_remove_search.sv
// A request is registered at accept and its response is registered into the output stage once
// that stage is free; one request in flight, so a new request is taken only after that.
// The row of cells shifts in the accept cycle; search matches are encoded when the response loads.
// Reset clears count, capacity (to 32) and handshake state; stored words are not cleared.
// Top level of the ordered list. Depends on oaisr_pkg, oaisr_ifs, oaisr_cell.
module ordered_array_insert_remove_search #(
  parameter int unsigned DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  oaisr_req_if.sink         req,
  oaisr_rsp_if.source       rsp,
  oaisr_cfg_if.sink         cfg
);

  localparam int unsigned CW = oaisr_pkg::CountW;
  localparam int unsigned DW = oaisr_pkg::DataW;
  localparam logic [CW-1:0] DepthCap = (DEPTH > 63) ? 6'd63 : 6'(DEPTH);

  logic [CW-1:0]         capacity;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [CW-1:0]         cap;
  logic                  busy;
  logic                  pend_search;
  logic [DW-1:0]         search_key;
  oaisr_pkg::status_t    pend_status;
  oaisr_pkg::status_t    status_next;
  oaisr_pkg::cmd_kind_t  kind_next;
  oaisr_pkg::cell_cmd_t  cmd;
  logic                  accept;
  logic                  load_out;
  logic [DW-1:0]         cell_data [DEPTH];
  logic [DEPTH-1:0]      match;
  logic                  any_match;
  logic [oaisr_pkg::PosW-1:0] first_pos;

  assign cfg.ready = 1'b1;
  assign req.ready = !busy;
  assign accept    = req.valid && !busy;
  assign cap       = (capacity > DepthCap) ? DepthCap : capacity;

  always_comb begin
    kind_next   = oaisr_pkg::CMD_HOLD;
    status_next = oaisr_pkg::ST_OK;
    count_next  = count;
    unique case (oaisr_pkg::op_t'(req.op))
      oaisr_pkg::OP_SEARCH: begin
        status_next = oaisr_pkg::ST_NOT_FOUND;
      end
      oaisr_pkg::OP_APPEND: begin
        if (count >= cap) begin
          status_next = oaisr_pkg::ST_FULL;
        end else begin
          kind_next  = oaisr_pkg::CMD_APPEND;
          count_next = count + CW'(1);
        end
      end
      oaisr_pkg::OP_INSERT: begin
        priority if ({1'b0, req.position} >= cap || {1'b0, req.position} > count) begin
          status_next = oaisr_pkg::ST_BAD_INDEX;
        end else if (count >= cap) begin
          status_next = oaisr_pkg::ST_FULL;
        end else begin
          kind_next  = oaisr_pkg::CMD_INSERT;
          count_next = count + CW'(1);
        end
      end
      oaisr_pkg::OP_REMOVE: begin
        if ({1'b0, req.position} >= count) begin
          status_next = oaisr_pkg::ST_BAD_INDEX;
        end else begin
          kind_next  = oaisr_pkg::CMD_REMOVE;
          count_next = count - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd.kind  = accept ? kind_next : oaisr_pkg::CMD_HOLD;
    cmd.pos   = req.position;
    cmd.count = count;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DW-1:0] left_data;
    logic [DW-1:0] right_data;
    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_left
      assign left_data = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_right
      assign right_data = cell_data[i+1];
    end
    oaisr_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .value     (req.value),
      .key       (search_key),
      .left_data (left_data),
      .right_data(right_data),
      .data      (cell_data[i]),
      .match     (match[i])
    );
  end

  // lowest matching index wins
  always_comb begin
    first_pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) first_pos = oaisr_pkg::PosW'(i);
    end
  end
  assign any_match = |match;

  assign load_out = busy && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= oaisr_pkg::CapReset;
      count     <= '0;
      busy      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg.valid) capacity <= cfg.data;
      if (accept) begin
        busy        <= 1'b1;
        count       <= count_next;
        search_key  <= req.value;
        pend_search <= (oaisr_pkg::op_t'(req.op) == oaisr_pkg::OP_SEARCH);
        pend_status <= status_next;
      end
      if (load_out) begin
        busy      <= 1'b0;
        rsp.valid <= 1'b1;
        rsp.count_after <= count;
        if (pend_search && any_match) begin
          rsp.status         <= oaisr_pkg::ST_OK;
          rsp.found_position <= first_pos;
        end else begin
          rsp.status         <= pend_search ? oaisr_pkg::ST_NOT_FOUND : pend_status;
          rsp.found_position <= '0;
        end
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

endmodule

FILE: src/oaisr_checker.sv
// Port-level checks for the ordered list and the bind that attaches them.
// Depends on oaisr_pkg and ordered_array_insert_remove_search.
module oaisr_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             req_valid,
  input logic                             req_ready,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input logic [oaisr_pkg::StatW-1:0]      rsp_status,
  input logic [oaisr_pkg::PosW-1:0]       rsp_found_position,
  input logic [oaisr_pkg::CountW-1:0]     rsp_count_after
);

  a_found_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != oaisr_pkg::ST_OK |-> rsp_found_position == '0)
    else $error("found_position nonzero on refused request");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  a_response_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !rsp_valid |=> ##1 rsp_valid)
    else $error("response missing after request");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count_after)
      && $stable(rsp_status))
    else $error("stalled response changed");

endmodule

bind ordered_array_insert_remove_search oaisr_checker u_oaisr_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_found_position(rsp.found_position),
  .rsp_count_after   (rsp.count_after)
);

FILE: dv/ordered_array_insert_remove_search_checker.sv
// Checker for the ordered array list: watches the request, response and capacity
// channels, keeps its own copy of the list and compares every response with it.
// Depends on oaisr_pkg and the channel interfaces in oaisr_ifs.
module ordered_array_insert_remove_search_checker #(
  parameter int unsigned DEPTH = 32
) (
  input  logic clk,
  input  logic rst,
  oaisr_req_if req,
  oaisr_rsp_if rsp,
  oaisr_cfg_if cfg,
  output int   fail_count,
  output int   outstanding,
  output int   list_len
);
  timeunit 1ns;
  timeprecision 1ps;
  import oaisr_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [PosW-1:0]   found_position;
    logic [CountW-1:0] count_after;
  } list_reply_t;

  logic signed [DataW-1:0] list_words[$];
  logic [CountW-1:0]       cap_limit;
  list_reply_t             expected_replies[$];

  task automatic report_mismatch(input string what);
    if (fail_count < 40) $display("[%0t] %m: %s", $time, what);
    fail_count++;
  endtask

  function automatic list_reply_t apply_list_op(input op_t op, input logic [PosW-1:0] pos,
                                                input logic signed [DataW-1:0] val);
    list_reply_t reply;
    int          limit;
    int          len;
    limit = (cap_limit > DEPTH) ? DEPTH : cap_limit;
    len = list_words.size();
    reply.status = ST_OK;
    reply.found_position = '0;
    case (op)
      OP_SEARCH: begin
        reply.status = ST_NOT_FOUND;
        for (int i = 0; i < len; i++) begin
          if (list_words[i] == val) begin
            reply.status = ST_OK;
            reply.found_position = PosW'(i);
            break;
          end
        end
      end
      OP_APPEND: begin
        if (len >= limit) reply.status = ST_FULL;
        else list_words.push_back(val);
      end
      OP_INSERT: begin
        if (pos >= limit || pos > len) reply.status = ST_BAD_INDEX;
        else if (len >= limit) reply.status = ST_FULL;
        else list_words.insert(pos, val);
      end
      default: begin
        if (pos >= len) reply.status = ST_BAD_INDEX;
        else list_words.delete(pos);
      end
    endcase
    reply.count_after = CountW'(list_words.size());
    return reply;
  endfunction

  always @(posedge clk) begin : watch
    list_reply_t want;
    if (rst) begin
      list_words.delete();
      expected_replies.delete();
      cap_limit = CapReset;
    end else begin
      if (cfg.valid && cfg.ready) cap_limit = cfg.data;
      if (req.valid && req.ready)
        expected_replies.push_back(apply_list_op(op_t'(req.op), req.position, req.value));
      if (rsp.valid && rsp.ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want = expected_replies.pop_front();
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
          if (rsp.found_position !== want.found_position)
            report_mismatch($sformatf("found_position %0d, expected %0d",
                                      rsp.found_position, want.found_position));
          if (rsp.count_after !== want.count_after)
            report_mismatch($sformatf("count_after %0d, expected %0d",
                                      rsp.count_after, want.count_after));
        end
      end
    end
    outstanding <= expected_replies.size();
    list_len    <= list_words.size();
  end

endmodule

FILE: dv/ordered_array_insert_remove_search_tb.sv
// Testbench top for the ordered array list: clock, reset, request traffic,
// response back-pressure and capacity writes; gives the verdict from the checker.
// Depends on oaisr_pkg, oaisr_ifs, the list block and its checker.
module ordered_array_insert_remove_search_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import oaisr_pkg::*;

  localparam int unsigned DEPTH = 32;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   idle_on;
  bit   long_hold;
  int   fail_count;
  int   outstanding;
  int   list_len;
  int   quiet_cycles;

  oaisr_req_if req_ch();
  oaisr_rsp_if rsp_ch();
  oaisr_cfg_if cfg_ch();

  ordered_array_insert_remove_search #(.DEPTH(DEPTH)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  ordered_array_insert_remove_search_checker #(.DEPTH(DEPTH)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg         (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .list_len    (list_len)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ordered_array_insert_remove_search_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input op_t op, input logic [PosW-1:0] pos,
                              input logic signed [DataW-1:0] val);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.op       <= op;
    req_ch.position <= pos;
    req_ch.value    <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic drain_replies();
    req_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CountW-1:0] cap);
    drain_replies();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= cap;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // response side: per-item stall, plus one long hold-off on request
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = idle_on ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  initial begin
    logic signed [DataW-1:0] value_pool [8];
    logic [CountW-1:0]       phase_caps [8];
    op_t                     op_sel;
    logic [PosW-1:0]         pos_sel;
    logic signed [DataW-1:0] val_sel;
    int                      r;
    int                      n_items;
    bit                      growing;
    req_ch.valid    = 1'b0;
    req_ch.op       = OP_SEARCH;
    req_ch.position = '0;
    req_ch.value    = '0;
    rsp_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    value_pool = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h1,
                   $urandom, $urandom, $urandom};
    phase_caps = '{6'd63, 6'd1, 6'd32, CountW'($urandom_range(1, 32)),
                   CountW'($urandom_range(33, 63)), 6'd0,
                   CountW'($urandom_range(1, 32)), 6'd32};
    idle_on = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_request(OP_SEARCH, 5'd0, 32'sd7);
    send_request(OP_REMOVE, 5'd0, 32'sd0);
    send_request(OP_INSERT, 5'd1, 32'sd9);
    send_request(OP_APPEND, 5'd31, 32'h8000_0000);
    send_request(OP_APPEND, 5'd0, 32'h7fff_ffff);
    send_request(OP_INSERT, 5'd0, -32'sd1);
    send_request(OP_INSERT, 5'd3, 32'sd0);
    send_request(OP_SEARCH, 5'd0, 32'h7fff_ffff);
    send_request(OP_SEARCH, 5'd0, 32'sd12345);
    send_request(OP_APPEND, 5'd0, -32'sd1);
    send_request(OP_SEARCH, 5'd0, -32'sd1);
    send_request(OP_REMOVE, 5'd31, 32'sd0);
    send_request(OP_REMOVE, 5'd4, 32'sd0);
    send_request(OP_REMOVE, 5'd0, 32'sd0);
    write_capacity(6'd2);
    send_request(OP_APPEND, 5'd0, 32'sd5);
    send_request(OP_INSERT, 5'd1, 32'sd5);
    send_request(OP_INSERT, 5'd2, 32'sd5);
    send_request(OP_REMOVE, 5'd0, 32'sd0);
    send_request(OP_REMOVE, 5'd0, 32'sd0);
    send_request(OP_APPEND, 5'd0, 32'sd5);
    send_request(OP_APPEND, 5'd0, 32'sd6);
    write_capacity(6'd0);
    send_request(OP_APPEND, 5'd0, 32'sd8);
    send_request(OP_INSERT, 5'd0, 32'sd8);
    send_request(OP_SEARCH, 5'd0, 32'sd5);

    for (int ph = 0; ph < 8; ph++) begin
      write_capacity(phase_caps[ph]);
      idle_on = (ph != 3) && ($urandom_range(0, 4) != 0);
      n_items = (phase_caps[ph] == 0) ? 40 : 260;
      for (int k = 0; k < n_items; k++) begin
        growing = k < n_items / 2;
        if (ph == 2 && k == n_items / 2) long_hold = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 20) op_sel = OP_SEARCH;
        else if (r < (growing ? 55 : 35)) op_sel = OP_APPEND;
        else if (r < (growing ? 85 : 50)) op_sel = OP_INSERT;
        else op_sel = OP_REMOVE;
        val_sel = ($urandom_range(0, 1) == 1) ? value_pool[$urandom_range(0, 7)] : $urandom;
        pos_sel = PosW'($urandom_range(0, 31));
        if ($urandom_range(0, 4) != 0) begin
          if (op_sel == OP_INSERT) pos_sel = PosW'($urandom_range(0, list_len));
          else if (op_sel == OP_REMOVE && list_len > 0)
            pos_sel = PosW'($urandom_range(0, list_len - 1));
        end
        send_request(op_sel, pos_sel, val_sel);
      end
    end

    drain_replies();
    if (fail_count == 0) begin
      $display("ordered_array_insert_remove_search_tb: PASS");
    end else begin
      $display("ordered_array_insert_remove_search_tb: FAIL");
    end
    $finish;
  end

endmodule
